// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the console cursor and scroll engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg
// Types, codes and reset constants of the text console cursor and scroll
// engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccs_pkg;

   // Widths of positions and fields
   localparam int POS_W  = 14;
   localparam int IDX_W  = 13;
   localparam int BYTE_W = 8;
   localparam int PROD_W = 17;
   localparam int CSR_IDX_W = 2;

   // Largest display memory in cells; the position widths are sized for it
   localparam int MAX_CELLS = 8192;

   // Register reset values
   localparam logic [BYTE_W-1:0] RESET_COLUMNS = 8'd80;
   localparam logic [BYTE_W-1:0] RESET_LINES   = 8'd25;
   localparam logic [POS_W-1:0]  RESET_BUFFER  = 14'd8192;
   // Screen end after reset: lines times columns of the reset values
   localparam logic [POS_W-1:0]  RESET_SCREEN_END = 14'd2000;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER  = 2'd2;

   // Control characters
   localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [BYTE_W-1:0] CHAR_TAB       = 8'd9;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'd10;

   // Remainder steps of the newline alignment, minus one
   localparam logic [BYTE_W-1:0] DIV_STEPS_M1 = 8'(POS_W - 1);

   typedef enum logic [2:0] {
      OP_WRITE_CHAR = 3'd0,
      OP_SET_CURSOR = 3'd1,
      OP_LINE_UP    = 3'd2,
      OP_LINE_DOWN  = 3'd3,
      OP_PAGE_UP    = 3'd4,
      OP_PAGE_DOWN  = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]        operation;
      logic [BYTE_W-1:0] char_code;
      logic [BYTE_W-1:0] row;
      logic [BYTE_W-1:0] col;
   } req_type;

   typedef struct packed {
      logic              cell_write;
      logic [IDX_W-1:0]  cell_index;
      logic [BYTE_W-1:0] cell_char;
      logic [POS_W-1:0]  cursor_cell;
      logic [IDX_W-1:0]  display_origin;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic exec_char;
      logic div_step;
      logic nl_fin;
      logic mul;
      logic set_fin;
      logic line_up;
      logic line_down;
      logic cnt_load;
      logic cnt_dec;
      logic load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [2:0] op;
      logic       is_newline;
      logic       cnt_zero;
      logic       up_ok;
      logic       down_ok;
      logic       scroll_due;
   } ctrl_status_type;

endpackage

// ===== sv/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console cursor and scroll engine.
// Each request transaction carries one console operation (write char, set
// cursor, line up/down, page up/down). Each yields exactly one response
// transaction with an optional character store, the cursor cell and the
// display origin, all counted in character cells.
// A request is taken only while the engine is idle; the response sits in an
// output register, so the next request is taken while it waits to be
// taken. Each operation runs from capture through the execute state to the
// done state, where the response is loaded: plain characters, tab and
// backspace pass the post state, set cursor (one 8x9 multiply) the set finish
// state; newline adds a 14-step remainder by the column count, one bit a
// cycle, and the align step before the post state; page scrolls move one
// line in each page step; line scrolls and unused codes go straight to done.
// Reset (synchronous) restores columns 80, lines 25, buffer 8192 cells,
// cursor and origin 0 and screen end 2000. A stalled response holds; the
// engine finishes its work and then waits before loading the next one.
// Configuration writes apply at once and are meant for idle periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_cursor_scroll #(
   parameter int TAB_STEP  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tccs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tccs_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_en,
   input  logic [tccs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tccs_pkg::POS_W-1:0]      csr_wdata
);

   tccs_pkg::ctrl_cmd_type    cmd;
   tccs_pkg::ctrl_status_type status;

   tccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tccs_datapath #(
      .TAB_STEP  (TAB_STEP)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_data     (rsp_data)
   );

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

endmodule

// ===== sv/tccs_datapath.sv =====
// ----------------------------------------------------------------------------
// tccs_datapath
// Configuration registers, cursor and scroll state, remainder unit for the
// newline alignment, set-cursor multiplier and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccs_datapath #(
   parameter int TAB_STEP  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tccs_pkg::ctrl_cmd_type             cmd,
   output tccs_pkg::ctrl_status_type          status,
   input  tccs_pkg::req_type                  req_data,
   input  logic                               csr_write_en,
   input  logic [tccs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tccs_pkg::POS_W-1:0]         csr_wdata,
   output tccs_pkg::rsp_type                  rsp_data
);

   localparam int POS_W  = tccs_pkg::POS_W;
   localparam int SUM_W  = POS_W + 1;
   localparam int BYTE_W = tccs_pkg::BYTE_W;
   localparam int PROD_W = tccs_pkg::PROD_W;
   localparam logic [POS_W-1:0] BUF_CAP_W = POS_W'(tccs_pkg::MAX_CELLS);
   localparam logic [SUM_W-1:0] TAB_W     = SUM_W'(TAB_STEP);

   // Configuration
   logic [BYTE_W-1:0] cols_ff, lines_ff;
   logic [POS_W-1:0]  bufc_ff;

   // Console state
   logic [POS_W-1:0]  cursor_ff, cursor_in;
   logic [POS_W-1:0]  origin_ff, origin_in;
   logic [POS_W-1:0]  send_ff, send_in;
   logic [BYTE_W-1:0] top_ff, top_in;

   // Transaction and work registers
   logic [2:0]                    op_ff;
   logic [BYTE_W-1:0]             ch_ff, row_ff, col_ff;
   logic                          wr_ff, wr_in;
   logic [tccs_pkg::IDX_W-1:0]    widx_ff, widx_in;
   logic [BYTE_W-1:0]             wch_ff, wch_in;
   logic [PROD_W-1:0]             prod_ff;
   logic [POS_W-1:0]              dvd_ff, dvd_in;
   logic [BYTE_W-1:0]             rem_ff, rem_in;
   logic [BYTE_W-1:0]             cnt_ff, cnt_in;
   tccs_pkg::rsp_type             rsp_ff;

   // Effective bounds
   logic [BYTE_W-1:0] eff_cols;
   logic [POS_W-1:0]  eff_buf;
   logic [SUM_W-1:0]  cols_s, buf_s, cursor_s, send_plus_c;
   logic              up_ok, down_ok;
   logic [BYTE_W:0]   rem_trial, rem_next;
   logic [PROD_W:0]   set_pos;

   assign eff_cols = (cols_ff == '0) ? BYTE_W'(1) : cols_ff;
   assign eff_buf  = (bufc_ff == '0) ? POS_W'(1) :
                     ((bufc_ff > BUF_CAP_W) ? BUF_CAP_W : bufc_ff);

   assign cols_s      = SUM_W'(eff_cols);
   assign buf_s       = SUM_W'(eff_buf);
   assign cursor_s    = SUM_W'(cursor_ff);
   assign send_plus_c = SUM_W'(send_ff) + cols_s;
   assign up_ok       = (send_plus_c <= buf_s);
   assign down_ok     = (origin_ff >= POS_W'(eff_cols));

   // One restoring remainder step per cycle
   assign rem_trial = {rem_ff, dvd_ff[POS_W-1]};
   assign rem_next  = (rem_trial >= {1'b0, eff_cols}) ? rem_trial - {1'b0, eff_cols}
                                                      : rem_trial;

   assign set_pos = (PROD_W+1)'(prod_ff) + (PROD_W+1)'(col_ff);

   // Next state of cursor, scroll state, store and remainder unit
   always_comb begin
      cursor_in = cursor_ff;
      origin_in = origin_ff;
      send_in   = send_ff;
      top_in    = top_ff;
      wr_in     = wr_ff;
      widx_in   = widx_ff;
      wch_in    = wch_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;

      if (cmd.capture) begin
         wr_in   = 1'b0;
         widx_in = '0;
         wch_in  = '0;
      end

      if (cmd.exec_char) begin
         case (ch_ff)
            tccs_pkg::CHAR_NEWLINE: begin
               if (cursor_s + cols_s < buf_s) begin
                  cursor_in = cursor_ff + POS_W'(eff_cols);
                  dvd_in    = cursor_ff + POS_W'(eff_cols);
               end else begin
                  dvd_in = cursor_ff;
               end
               rem_in = '0;
               cnt_in = tccs_pkg::DIV_STEPS_M1;
            end
            tccs_pkg::CHAR_TAB: begin
               if (cursor_s + TAB_W < buf_s) begin
                  cursor_in = cursor_ff + POS_W'(TAB_STEP);
               end
            end
            tccs_pkg::CHAR_BACKSPACE: begin
               if (cursor_ff != '0) begin
                  cursor_in = cursor_ff - POS_W'(1);
               end
            end
            default: begin
               if (cursor_ff < eff_buf) begin
                  wr_in     = 1'b1;
                  widx_in   = cursor_ff[tccs_pkg::IDX_W-1:0];
                  wch_in    = ch_ff;
                  cursor_in = cursor_ff + POS_W'(1);
               end
            end
         endcase
      end

      if (cmd.div_step) begin
         rem_in = rem_next[BYTE_W-1:0];
         dvd_in = {dvd_ff[POS_W-2:0], 1'b0};
         cnt_in = cnt_ff - BYTE_W'(1);
      end

      // Align to column zero
      if (cmd.nl_fin) begin
         cursor_in = cursor_ff - POS_W'(rem_ff);
      end

      // Saturate the set-cursor position at the buffer end
      if (cmd.set_fin) begin
         cursor_in = (set_pos > (PROD_W+1)'(eff_buf)) ? eff_buf : set_pos[POS_W-1:0];
      end

      if (cmd.line_up && up_ok) begin
         origin_in = origin_ff + POS_W'(eff_cols);
         send_in   = send_plus_c[POS_W-1:0];
         top_in    = top_ff + BYTE_W'(1);
      end

      if (cmd.line_down && down_ok) begin
         origin_in = origin_ff - POS_W'(eff_cols);
         send_in   = (send_ff >= POS_W'(eff_cols)) ? send_ff - POS_W'(eff_cols) : '0;
         top_in    = top_ff - BYTE_W'(1);
      end

      if (cmd.cnt_load) begin
         cnt_in = lines_ff;
      end
      if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - BYTE_W'(1);
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= tccs_pkg::RESET_COLUMNS;
         lines_ff <= tccs_pkg::RESET_LINES;
         bufc_ff  <= tccs_pkg::RESET_BUFFER;
      end else if (csr_write_en) begin
         case (csr_index)
            tccs_pkg::CSR_COLUMNS: cols_ff  <= csr_wdata[BYTE_W-1:0];
            tccs_pkg::CSR_LINES:   lines_ff <= csr_wdata[BYTE_W-1:0];
            tccs_pkg::CSR_BUFFER:  bufc_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Console state
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         origin_ff <= '0;
         send_ff   <= tccs_pkg::RESET_SCREEN_END;
         top_ff    <= '0;
      end else begin
         cursor_ff <= cursor_in;
         origin_ff <= origin_in;
         send_ff   <= send_in;
         top_ff    <= top_in;
      end
   end

   // Transaction payload and work registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_data.operation;
         ch_ff  <= req_data.char_code;
         row_ff <= req_data.row;
         col_ff <= req_data.col;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(eff_cols) * PROD_W'({1'b0, top_ff} + {1'b0, row_ff});
      end
      if (cmd.load_rsp) begin
         rsp_ff.cell_write     <= wr_ff;
         rsp_ff.cell_index     <= widx_ff;
         rsp_ff.cell_char      <= wch_ff;
         rsp_ff.cursor_cell    <= cursor_ff;
         rsp_ff.display_origin <= origin_ff[tccs_pkg::IDX_W-1:0];
      end
      wr_ff   <= wr_in;
      widx_ff <= widx_in;
      wch_ff  <= wch_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign status.op         = op_ff;
   assign status.is_newline = (ch_ff == tccs_pkg::CHAR_NEWLINE);
   assign status.cnt_zero   = (cnt_ff == '0);
   assign status.up_ok      = up_ok;
   assign status.down_ok    = down_ok;
   assign status.scroll_due = (cursor_ff >= send_ff);

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/tccs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tccs_ctrl
// Controller of the console engine: sequences one operation through the
// datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tccs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  tccs_pkg::ctrl_status_type  status,
   output tccs_pkg::ctrl_cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_NL_FIN,
      S_SET_FIN,
      S_POST,
      S_PAGE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      page_ok;

   assign page_ok = (status.op == tccs_pkg::OP_PAGE_UP) ? status.up_ok : status.down_ok;

   // Next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (status.op)
               tccs_pkg::OP_WRITE_CHAR: begin
                  cmd.exec_char = 1'b1;
                  state_in      = status.is_newline ? S_DIV : S_POST;
               end
               tccs_pkg::OP_SET_CURSOR: begin
                  cmd.mul  = 1'b1;
                  state_in = S_SET_FIN;
               end
               tccs_pkg::OP_LINE_UP: begin
                  cmd.line_up = 1'b1;
                  state_in    = S_DONE;
               end
               tccs_pkg::OP_LINE_DOWN: begin
                  cmd.line_down = 1'b1;
                  state_in      = S_DONE;
               end
               tccs_pkg::OP_PAGE_UP, tccs_pkg::OP_PAGE_DOWN: begin
                  cmd.cnt_load = 1'b1;
                  state_in     = S_PAGE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.cnt_zero) begin
               state_in = S_NL_FIN;
            end
         end
         S_NL_FIN: begin
            cmd.nl_fin = 1'b1;
            state_in   = S_POST;
         end
         S_POST: begin
            // Scroll once when the cursor reached or ran past the screen end
            cmd.line_up = status.scroll_due;
            state_in    = S_DONE;
         end
         S_SET_FIN: begin
            cmd.set_fin = 1'b1;
            state_in    = S_DONE;
         end
         S_PAGE: begin
            if (status.cnt_zero || !page_ok) begin
               state_in = S_DONE;
            end else begin
               cmd.line_up   = (status.op == tccs_pkg::OP_PAGE_UP);
               cmd.line_down = (status.op != tccs_pkg::OP_PAGE_UP);
               cmd.cnt_dec   = 1'b1;
            end
         end
         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_IMPLIES(a_load_only_when_free, clock, reset, cmd.load_rsp, !(rsp_valid_ff && rsp_stall))
   `ASSERT_IMPLIES(a_rsp_rise_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE))
   `ASSERT_IMPLIES(a_div_only_newline, clock, reset, state_ff == S_DIV, (status.op == tccs_pkg::OP_WRITE_CHAR) && status.is_newline)

endmodule

// ===== test/text_console_cursor_scroll_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb
// Self-checking bench for the text console cursor and scroll engine. A short
// table of console operations runs first, with hand-computed responses where
// they are obvious. It is followed by phases of random operations under
// several screen geometries. A cycle-free model of the cursor, origin, screen
// end and top row predicts each response. Both sides idle and stall in random
// bursts, and one long receiver hold-off backs the engine up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_scroll_tb;

   localparam int MAX_CELLS   = 8192;
   localparam int TAB_CELLS   = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      tccs_pkg::req_type item;
      bit                typed;
      tccs_pkg::rsp_type rsp;
   } console_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tccs_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tccs_pkg::rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [tccs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tccs_pkg::POS_W-1:0] csr_wdata = '0;

   // Hand-computed response that travels with a directed transaction
   logic tag_typed = 1'b0;
   tccs_pkg::rsp_type tag_rsp = '0;

   // Model state and geometry registers
   int cur_pos = 0;
   int org_cell = 0;
   int scr_end = int'(tccs_pkg::RESET_SCREEN_END);
   int top_line = 0;
   int cfg_columns = int'(tccs_pkg::RESET_COLUMNS);
   int cfg_lines = int'(tccs_pkg::RESET_LINES);
   int cfg_buffer = int'(tccs_pkg::RESET_BUFFER);

   tccs_pkg::rsp_type expected_rsp_q[$];
   int mismatch_count = 0;
   bit calm = 1'b0;
   bit hold_pending = 1'b0;

   text_console_cursor_scroll i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Geometry as the engine sees it
   function automatic int eff_columns();
      return (cfg_columns == 0) ? 1 : cfg_columns;
   endfunction

   function automatic int eff_buffer();
      if (cfg_buffer == 0) return 1;
      if (cfg_buffer > MAX_CELLS) return MAX_CELLS;
      return cfg_buffer;
   endfunction

   function automatic bit scroll_line_up();
      int c;
      c = eff_columns();
      if (scr_end + c > eff_buffer()) return 1'b0;
      org_cell += c;
      scr_end += c;
      top_line = (top_line + 1) & 8'hFF;
      return 1'b1;
   endfunction

   function automatic bit scroll_line_down();
      int c;
      c = eff_columns();
      if (org_cell < c) return 1'b0;
      org_cell -= c;
      scr_end = (scr_end >= c) ? scr_end - c : 0;
      top_line = (top_line - 1) & 8'hFF;
      return 1'b1;
   endfunction

   // Apply one console operation to the model and return its response
   function automatic tccs_pkg::rsp_type console_step(tccs_pkg::req_type r);
      tccs_pkg::rsp_type res;
      int c;
      int b;
      int p;
      int n;
      c = eff_columns();
      b = eff_buffer();
      res = '0;
      case (r.operation)
         tccs_pkg::OP_WRITE_CHAR: begin
            if (r.char_code == tccs_pkg::CHAR_NEWLINE) begin
               if (cur_pos + c < b) cur_pos += c;
               cur_pos -= cur_pos % c;
            end else if (r.char_code == tccs_pkg::CHAR_TAB) begin
               if (cur_pos + TAB_CELLS < b) cur_pos += TAB_CELLS;
            end else if (r.char_code == tccs_pkg::CHAR_BACKSPACE) begin
               if (cur_pos > 0) cur_pos -= 1;
            end else if (cur_pos < b) begin
               res.cell_write = 1'b1;
               res.cell_index = tccs_pkg::IDX_W'(cur_pos);
               res.cell_char = r.char_code;
               cur_pos += 1;
            end
            if (cur_pos >= scr_end) void'(scroll_line_up());
         end
         tccs_pkg::OP_SET_CURSOR: begin
            p = c * (top_line + int'(r.row)) + int'(r.col);
            cur_pos = (p > b) ? b : p;
         end
         tccs_pkg::OP_LINE_UP: void'(scroll_line_up());
         tccs_pkg::OP_LINE_DOWN: void'(scroll_line_down());
         tccs_pkg::OP_PAGE_UP: begin
            for (n = 0; n < cfg_lines; n++) begin
               if (!scroll_line_up()) break;
            end
         end
         tccs_pkg::OP_PAGE_DOWN: begin
            for (n = 0; n < cfg_lines; n++) begin
               if (!scroll_line_down()) break;
            end
         end
         default: ;
      endcase
      res.cursor_cell = tccs_pkg::POS_W'(cur_pos);
      res.display_origin = tccs_pkg::IDX_W'(org_cell);
      return res;
   endfunction

   function automatic console_row_type mk_row(logic [2:0] op, int ch, int row, int col,
                                             bit typed, tccs_pkg::rsp_type rsp);
      console_row_type t;
      t.item.operation = op;
      t.item.char_code = tccs_pkg::BYTE_W'(ch);
      t.item.row = tccs_pkg::BYTE_W'(row);
      t.item.col = tccs_pkg::BYTE_W'(col);
      t.typed = typed;
      t.rsp = rsp;
      return t;
   endfunction

   function automatic void check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         mismatch_count++;
      end
   endfunction

   // Predict on every accepted request transaction
   always @(posedge clock) begin
      tccs_pkg::rsp_type exp_rsp;
      if (!reset && req_valid && !req_stall) begin
         exp_rsp = console_step(req_data);
         if (tag_typed) exp_rsp = tag_rsp;
         expected_rsp_q.push_back(exp_rsp);
      end
   end

   // Compare every accepted response transaction with the oldest prediction
   always @(posedge clock) begin
      tccs_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response transaction with nothing pending");
            mismatch_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            check_field("cell_write", exp_rsp.cell_write, rsp_data.cell_write);
            check_field("cell_index", exp_rsp.cell_index, rsp_data.cell_index);
            check_field("cell_char", exp_rsp.cell_char, rsp_data.cell_char);
            check_field("cursor_cell", exp_rsp.cursor_cell, rsp_data.cursor_cell);
            check_field("display_origin", exp_rsp.display_origin,
                        rsp_data.display_origin);
         end
      end
   end

   // Receiver: random stall bursts, quiet stretches and one long hold-off
   initial begin
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            if (hold_pending) begin
               stall_left = HOLD_CYCLES;
               hold_pending = 1'b0;
            end else if (free_left > 0) begin
               free_left--;
            end else if (!calm) begin
               if ($urandom_range(0, 39) == 0) free_left = $urandom_range(20, 80);
               else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 19);
            end
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // Offer one request transaction and hold it until accepted
   task automatic send_item(tccs_pkg::req_type item, bit typed, tccs_pkg::rsp_type rsp);
      if (!calm && !hold_pending && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      tag_typed <= typed;
      tag_rsp <= rsp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic run_random(int count);
      tccs_pkg::req_type item;
      int k;
      int sub;
      repeat (count) begin
         item.operation = OP_SPARE_6;
         item.char_code = tccs_pkg::BYTE_W'($urandom_range(0, 255));
         item.row = tccs_pkg::BYTE_W'($urandom_range(0, 255));
         item.col = tccs_pkg::BYTE_W'($urandom_range(0, 255));
         k = $urandom_range(0, 99);
         if (k < 55) begin
            item.operation = tccs_pkg::OP_WRITE_CHAR;
            sub = $urandom_range(0, 9);
            if (sub == 0) item.char_code = tccs_pkg::CHAR_NEWLINE;
            else if (sub == 1) item.char_code = tccs_pkg::CHAR_TAB;
            else if (sub == 2) item.char_code = tccs_pkg::CHAR_BACKSPACE;
         end else if (k < 67) begin
            item.operation = tccs_pkg::OP_SET_CURSOR;
            if ($urandom_range(0, 3) != 0) begin
               item.row = tccs_pkg::BYTE_W'($urandom_range(0, 30));
               item.col = tccs_pkg::BYTE_W'($urandom_range(0, 90));
            end
         end else if (k < 77) begin
            item.operation = tccs_pkg::OP_LINE_UP;
         end else if (k < 85) begin
            item.operation = tccs_pkg::OP_LINE_DOWN;
         end else if (k < 90) begin
            item.operation = tccs_pkg::OP_PAGE_UP;
         end else if (k < 95) begin
            item.operation = tccs_pkg::OP_PAGE_DOWN;
         end else begin
            item.operation = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
         end
         send_item(item, 1'b0, '0);
      end
      req_valid <= 1'b0;
   endtask

   // Drain, let the engine settle, then load all three geometry registers
   task automatic write_geometry(int cols, int lns, int cells);
      // Step past the last accept so its prediction is already queued
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= tccs_pkg::CSR_COLUMNS;
      csr_wdata <= tccs_pkg::POS_W'(cols);
      @(posedge clock);
      csr_index <= tccs_pkg::CSR_LINES;
      csr_wdata <= tccs_pkg::POS_W'(lns);
      @(posedge clock);
      csr_index <= tccs_pkg::CSR_BUFFER;
      csr_wdata <= tccs_pkg::POS_W'(cells);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_columns = cols & 8'hFF;
      cfg_lines = lns & 8'hFF;
      cfg_buffer = cells & 14'h3FFF;
   endtask

   // Stimulus
   initial begin
      console_row_type dir_table[21];
      tccs_pkg::req_type page_item;
      int i;

      dir_table[0] = mk_row(tccs_pkg::OP_WRITE_CHAR, 8'h41, 0, 0, 1'b1,
                            '{1'b1, 13'd0, 8'h41, 14'd1, 13'd0});
      dir_table[1] = mk_row(tccs_pkg::OP_WRITE_CHAR, 8'hFF, 255, 255, 1'b1,
                            '{1'b1, 13'd1, 8'hFF, 14'd2, 13'd0});
      dir_table[2] = mk_row(tccs_pkg::OP_WRITE_CHAR, 8'h00, 0, 0, 1'b1,
                            '{1'b1, 13'd2, 8'h00, 14'd3, 13'd0});
      dir_table[3] = mk_row(tccs_pkg::OP_WRITE_CHAR, tccs_pkg::CHAR_BACKSPACE, 0, 0, 1'b1,
                            '{1'b0, 13'd0, 8'd0, 14'd2, 13'd0});
      dir_table[4] = mk_row(tccs_pkg::OP_WRITE_CHAR, tccs_pkg::CHAR_TAB, 0, 0, 1'b1,
                            '{1'b0, 13'd0, 8'd0, 14'd10, 13'd0});
      dir_table[5] = mk_row(tccs_pkg::OP_WRITE_CHAR, tccs_pkg::CHAR_NEWLINE, 0, 0, 1'b1,
                            '{1'b0, 13'd0, 8'd0, 14'd80, 13'd0});
      dir_table[6] = mk_row(tccs_pkg::OP_SET_CURSOR, 0, 0, 0, 1'b1,
                            '{1'b0, 13'd0, 8'd0, 14'd0, 13'd0});
      // Backspace at cell zero stays put
      dir_table[7] = mk_row(tccs_pkg::OP_WRITE_CHAR, tccs_pkg::CHAR_BACKSPACE, 0, 0, 1'b1,
                            '{1'b0, 13'd0, 8'd0, 14'd0, 13'd0});
      // Set cursor far past the buffer saturates at the buffer size
      dir_table[8] = mk_row(tccs_pkg::OP_SET_CURSOR, 0, 255, 255, 1'b1,
                            '{1'b0, 13'd0, 8'd0, 14'd8192, 13'd0});
      // No store at the buffer end, but the screen still scrolls one line
      dir_table[9] = mk_row(tccs_pkg::OP_WRITE_CHAR, 8'h78, 0, 0, 1'b1,
                            '{1'b0, 13'd0, 8'd0, 14'd8192, 13'd80});
      dir_table[10] = mk_row(tccs_pkg::OP_LINE_DOWN, 0, 0, 0, 1'b1,
                             '{1'b0, 13'd0, 8'd0, 14'd8192, 13'd0});
      dir_table[11] = mk_row(tccs_pkg::OP_LINE_DOWN, 0, 0, 0, 1'b1,
                             '{1'b0, 13'd0, 8'd0, 14'd8192, 13'd0});
      dir_table[12] = mk_row(tccs_pkg::OP_PAGE_UP, 0, 0, 0, 1'b1,
                             '{1'b0, 13'd0, 8'd0, 14'd8192, 13'd2000});
      dir_table[13] = mk_row(tccs_pkg::OP_PAGE_DOWN, 0, 0, 0, 1'b1,
                             '{1'b0, 13'd0, 8'd0, 14'd8192, 13'd0});
      dir_table[14] = mk_row(tccs_pkg::OP_LINE_UP, 0, 0, 0, 1'b1,
                             '{1'b0, 13'd0, 8'd0, 14'd8192, 13'd80});
      // Unused operation codes only report the position
      dir_table[15] = mk_row(OP_SPARE_6, 8'hFF, 255, 255, 1'b1,
                             '{1'b0, 13'd0, 8'd0, 14'd8192, 13'd80});
      dir_table[16] = mk_row(OP_SPARE_7, 8'h41, 3, 4, 1'b1,
                             '{1'b0, 13'd0, 8'd0, 14'd8192, 13'd80});
      dir_table[17] = mk_row(tccs_pkg::OP_SET_CURSOR, 0, 10, 5, 1'b1,
                             '{1'b0, 13'd0, 8'd0, 14'd885, 13'd80});
      dir_table[18] = mk_row(tccs_pkg::OP_WRITE_CHAR, tccs_pkg::CHAR_TAB, 0, 0, 1'b0, '0);
      dir_table[19] = mk_row(tccs_pkg::OP_WRITE_CHAR, tccs_pkg::CHAR_NEWLINE, 0, 0, 1'b0,
                             '0);
      dir_table[20] = mk_row(tccs_pkg::OP_WRITE_CHAR, 8'h7E, 0, 0, 1'b0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (i = 0; i < 21; i++) begin
         send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].rsp);
      end
      req_valid <= 1'b0;

      // Reset geometry, with the long receiver hold-off
      hold_pending = 1'b1;
      run_random(60);

      // One-cell rows, deepest pages: the top row wraps
      write_geometry(1, 255, 8192);
      page_item = '{tccs_pkg::OP_PAGE_UP, 8'd0, 8'd0, 8'd0};
      repeat (2) send_item(page_item, 1'b0, '0);
      req_valid <= 1'b0;
      run_random(60);

      write_geometry(255, 1, 8192);
      run_random(40);

      // Zero columns, zero lines and an empty buffer
      write_geometry(0, 0, 0);
      run_random(40);

      // Buffer size above the maximum
      write_geometry(40, 12, 16383);
      run_random(40);

      write_geometry(7, 3, 300);
      run_random(40);

      repeat (2) begin
         write_geometry($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 16383));
         run_random(30);
      end

      // Last part without idling
      calm = 1'b1;
      write_geometry(80, 25, 8192);
      run_random(60);

      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
